// ===== design/lsm_pkg.sv =====
package lsm_pkg;

    localparam int PATTERN_MAX = 16;
    localparam int LINE_W      = 32;
    localparam int OFFSET_W    = 16;

    localparam int PAT_BYTES   = 16;
    localparam int LEN_W       = 5;
    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int PTR_W       = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    localparam longint unsigned COUNT_MAX_L =
        ((64'd1 << OFFSET_W) - 64'd1) + 64'(PATTERN_MAX);
    localparam int COUNT_W = $clog2(COUNT_MAX_L + 64'd1);

    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN  = 2'd2;

    localparam logic [7:0] NEWLINE = 8'd10;

    typedef struct packed {
        logic       adv;
        logic       file_start;
        logic [7:0] data_byte;
    } t_step;

endpackage

// ===== design/lsm_window.sv =====
module lsm_window (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lsm_pkg::t_step                i_step,
    input  logic [lsm_pkg::PAT_BYTES*8-1:0] i_pattern,
    input  logic [lsm_pkg::LEN_W-1:0]     i_len,
    output logic                          o_hit
);

    logic [7:0] r_win [lsm_pkg::PATTERN_MAX];
    logic [7:0] n_win [lsm_pkg::PATTERN_MAX];
    logic [lsm_pkg::LEN_W-1:0] pos;
    logic                      mismatch;

    always_comb begin
        n_win[0] = i_step.data_byte;
        for (int i = 1; i < lsm_pkg::PATTERN_MAX; i++) begin
            n_win[i] = i_step.file_start ? 8'd0 : r_win[i-1];
        end
    end

    always_comb begin
        mismatch = 1'b0;
        pos      = '0;
        for (int k = 0; k < lsm_pkg::PATTERN_MAX; k++) begin
            if (k < int'(i_len)) begin
                pos = i_len - lsm_pkg::LEN_W'(k + 1);
                if (n_win[pos[lsm_pkg::PTR_W-1:0]] != i_pattern[k*8 +: 8]) begin
                    mismatch = 1'b1;
                end
            end
        end
        o_hit = (i_len != '0) && !mismatch;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < lsm_pkg::PATTERN_MAX; i++) begin
                r_win[i] <= 8'd0;
            end
        end else if (i_step.adv) begin
            for (int i = 0; i < lsm_pkg::PATTERN_MAX; i++) begin
                r_win[i] <= n_win[i];
            end
        end
    end

endmodule

// ===== design/lsm_counter.sv =====
module lsm_counter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lsm_pkg::t_step                i_step,
    input  logic [lsm_pkg::LEN_W-1:0]     i_len,
    output logic                          o_long_enough,
    output logic [lsm_pkg::LINE_W-1:0]    o_line,
    output logic [lsm_pkg::OFFSET_W-1:0]  o_offset
);

    localparam logic [lsm_pkg::COUNT_W-1:0] COUNT_MAX =
        lsm_pkg::COUNT_W'(lsm_pkg::COUNT_MAX_L);
    localparam logic [lsm_pkg::LINE_W-1:0]   LINE_MAX = '1;
    localparam logic [lsm_pkg::OFFSET_W-1:0] OFF_MAX  = '1;

    logic [lsm_pkg::LINE_W-1:0]  r_line, n_line, line_base;
    logic [lsm_pkg::COUNT_W-1:0] r_count, n_count, count_base, diff, len_ext;
    logic                        r_at_start, at_start;

    always_comb begin
        line_base  = i_step.file_start ? '0 : r_line;
        at_start   = i_step.file_start || r_at_start;
        n_line     = line_base;
        count_base = r_count;
        if (at_start) begin
            n_line     = (line_base == LINE_MAX) ? LINE_MAX : line_base + 1'b1;
            count_base = '0;
        end
        n_count = (count_base == COUNT_MAX) ? COUNT_MAX : count_base + 1'b1;

        len_ext       = lsm_pkg::COUNT_W'(i_len);
        o_long_enough = (n_count >= len_ext);
        diff          = n_count - len_ext;
        o_offset      = (diff > lsm_pkg::COUNT_W'(OFF_MAX)) ? OFF_MAX
                                                           : diff[lsm_pkg::OFFSET_W-1:0];
        o_line        = n_line;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line     <= '0;
            r_count    <= '0;
            r_at_start <= 1'b1;
        end else if (i_step.adv) begin
            r_line     <= n_line;
            r_count    <= n_count;
            r_at_start <= (i_step.data_byte == lsm_pkg::NEWLINE);
        end
    end

endmodule

// ===== design/line_substring_matcher.sv =====
// Channel   Dir  Payload                                   Handshake
// s_axis    in   tdata[7:0] data_byte, tuser[0] file_start tvalid/tready
// m_axis    out  tdata[31:0] match_line, [47:32] offset    tvalid/tready
// cfg       in   index 0 low bytes, 1 high bytes, 2 length i_cfg_we
//
// One word per cycle sustained while m_axis does not back-pressure. A word is
// held in the input register, then the window compare and counter update
// write the result register, which presents a match on m_axis. The input
// stage stalls only when the result register is full and m_axis_tready is
// low. Reset is synchronous; no clearing pass.
module line_substring_matcher (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,   // data_byte
    input  logic                             s_axis_tuser,   // file_start
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [lsm_pkg::LINE_W+lsm_pkg::OFFSET_W-1:0] m_axis_tdata, // match_line, match_offset
    input  logic                             i_cfg_we,
    input  logic [lsm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lsm_pkg::CFG_W-1:0]        i_cfg_data
);

    logic [lsm_pkg::CFG_W-1:0] r_pat_low, r_pat_high;
    logic [lsm_pkg::LEN_W-1:0] r_pat_len, len_eff;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_start;

    logic                         r_out_valid;
    logic [lsm_pkg::LINE_W-1:0]   r_out_line;
    logic [lsm_pkg::OFFSET_W-1:0] r_out_off;

    lsm_pkg::t_step               step;
    logic                         adv, win_hit, long_enough;
    logic [lsm_pkg::LINE_W-1:0]   line;
    logic [lsm_pkg::OFFSET_W-1:0] offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= '0;
            r_pat_high <= '0;
            r_pat_len  <= lsm_pkg::LEN_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                lsm_pkg::CFG_PAT_LOW:  r_pat_low  <= i_cfg_data;
                lsm_pkg::CFG_PAT_HIGH: r_pat_high <= i_cfg_data;
                lsm_pkg::CFG_PAT_LEN:  r_pat_len  <= i_cfg_data[lsm_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign len_eff = (r_pat_len > lsm_pkg::LEN_W'(lsm_pkg::PATTERN_MAX))
                   ? lsm_pkg::LEN_W'(lsm_pkg::PATTERN_MAX) : r_pat_len;

    assign adv           = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte  <= s_axis_tdata;
            r_in_start <= s_axis_tuser;
        end
    end

    assign step.adv        = adv;
    assign step.file_start = r_in_start;
    assign step.data_byte  = r_in_byte;

    lsm_window u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_pattern ({r_pat_high, r_pat_low}),
        .i_len     (len_eff),
        .o_hit     (win_hit)
    );

    lsm_counter u_counter (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_len         (len_eff),
        .o_long_enough (long_enough),
        .o_line        (line),
        .o_offset      (offset)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= win_hit && long_enough;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_line <= line;
            r_out_off  <= offset;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_off, r_out_line};

endmodule

// ===== test/tb_top.sv =====
module tb_top;
    import lsm_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int unsigned BYTE_COUNT_MAX = (1 << OFFSET_W) - 1 + PATTERN_MAX;
    localparam int unsigned STUCK_LIMIT = 2000;
    localparam int unsigned LONG_HOLD = 300;
    localparam logic [7:0] CHAR_A = 8'h61;
    localparam logic [7:0] CHAR_B = 8'h62;

    typedef struct packed {
        logic       file_start;
        logic [7:0] data_byte;
    } byte_word_t;

    typedef struct packed {
        logic [OFFSET_W-1:0] offset;
        logic [LINE_W-1:0]   line_no;
    } match_t;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [7:0]                 s_axis_tdata = '0;   // data_byte
    logic                       s_axis_tuser = 1'b0; // file_start
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [LINE_W+OFFSET_W-1:0] m_axis_tdata;        // match_line, match_offset
    logic                       i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_index = CFG_PAT_LOW;
    logic [CFG_W-1:0]           i_cfg_data = '0;

    byte_word_t  pending_bytes[$];
    match_t      match_q[$];
    int unsigned mismatches = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    bit          hold_phase = 1'b0;
    bit          hold_done = 1'b0;
    int unsigned hold_left = 0;
    int unsigned stuck_cycles = 0;

    // predictor state and its copy of the registers
    logic [8*PAT_BYTES-1:0] pat_text = '0;
    logic [LEN_W-1:0]       pat_len = 5'd1;
    logic [7:0]             recent[PATTERN_MAX];
    logic [COUNT_W-1:0]     line_bytes = '0;
    logic [LINE_W-1:0]      line_count = '0;
    bit                     fresh_line = 1'b1;

    line_substring_matcher dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic int eff_len();
        return (pat_len > PATTERN_MAX) ? PATTERN_MAX : int'(pat_len);
    endfunction

    function automatic bit scan_byte(input logic [7:0] b, input logic start,
                                     output logic [LINE_W-1:0] ln,
                                     output logic [OFFSET_W-1:0] off);
        int  len;
        bit  hit;
        logic [COUNT_W-1:0] first;
        if (start) begin
            for (int i = 0; i < PATTERN_MAX; i++) recent[i] = 8'h00;
            line_bytes = '0;
            line_count = '0;
            fresh_line = 1'b1;
        end
        if (fresh_line) begin
            if (line_count != '1) line_count = line_count + 1'b1;
            line_bytes = '0;
            fresh_line = 1'b0;
        end
        for (int i = PATTERN_MAX - 1; i > 0; i--) recent[i] = recent[i-1];
        recent[0] = b;
        if (line_bytes < BYTE_COUNT_MAX) line_bytes = line_bytes + 1'b1;
        if (b == NEWLINE) fresh_line = 1'b1;
        len = eff_len();
        hit = (len != 0) && (line_bytes >= len);
        for (int k = 0; k < len; k++)
            if (recent[len-1-k] != pat_text[8*k +: 8]) hit = 1'b0;
        first = line_bytes - COUNT_W'(len);
        off = (first > {OFFSET_W{1'b1}}) ? {OFFSET_W{1'b1}} : first[OFFSET_W-1:0];
        ln = line_count;
        return hit;
    endfunction

    task automatic push(input logic [7:0] b, input logic s);
        pending_bytes.insert(pending_bytes.size(), {s, b});
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_PAT_LOW:  pat_text[63:0] = val;
            CFG_PAT_HIGH: pat_text[127:64] = val;
            CFG_PAT_LEN:  pat_len = val[LEN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        do @(negedge i_clk);
        while (pending_bytes.size() != 0 || s_axis_tvalid || match_q.size() != 0);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic set_mode(input int m);
        case (m)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
            default: begin send_idle_pct = 20; recv_stall_pct = 20; end
        endcase
    endtask

    // driver
    always @(posedge i_clk) begin
        byte_word_t w;
        logic [LINE_W-1:0] ln;
        logic [OFFSET_W-1:0] off;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                if (scan_byte(s_axis_tdata, s_axis_tuser, ln, off))
                    match_q.insert(match_q.size(), {off, ln});
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    w = pending_bytes.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= w.data_byte;
                    s_axis_tuser <= w.file_start;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        match_t want;
        match_t got;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            got = m_axis_tdata;
            if (m_axis_tvalid && m_axis_tready) begin
                if (match_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected match line %0d offset %0d",
                             $time, got.line_no, got.offset);
                end else begin
                    want = match_q.pop_front();
                    if (want.line_no != got.line_no || want.offset != got.offset) begin
                        mismatches++;
                        $display("%0t: expected line %0d offset %0d, got line %0d offset %0d",
                                 $time, want.line_no, want.offset, got.line_no, got.offset);
                    end
                end
            end
            if (hold_left != 0) begin
                m_axis_tready <= 1'b0;
                hold_left <= hold_left - 1;
            end else if (hold_phase && !hold_done && m_axis_tvalid && m_axis_tready) begin
                m_axis_tready <= 1'b0;
                hold_left <= LONG_HOLD;
                hold_done <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial begin
        int k, r, n, sent, glen;
        logic [7:0] b;
        logic [8*PAT_BYTES-1:0] pat;
        int lens[8];
        lens = '{1, 16, 0, 5, 20, 2, 31, 9};
        for (int i = 0; i < PATTERN_MAX; i++) recent[i] = 8'h00;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_mode(0);

        // reset pattern: one zero byte
        push(8'h00, 1'b1);
        push(8'hFF, 1'b0);
        push(NEWLINE, 1'b0);
        push(8'h00, 1'b0);
        push(NEWLINE, 1'b0);
        drain();

        // pattern spans a line break: never matches across lines
        set_reg(CFG_PAT_LOW, {40'h0, 8'h63, NEWLINE, CHAR_B});
        set_reg(CFG_PAT_LEN, 64'd3);
        set_reg(CFG_SPARE, {$urandom, $urandom});
        push(CHAR_A, 1'b1);
        push(CHAR_B, 1'b0);
        push(NEWLINE, 1'b0);
        push(8'h63, 1'b0);
        drain();

        // overlapping matches
        set_reg(CFG_PAT_LOW, {48'h0, CHAR_A, CHAR_A});
        set_reg(CFG_PAT_LEN, 64'd2);
        for (k = 0; k < 4; k++) push(CHAR_A, k == 0);
        drain();

        // full-width pattern, oversized length clamps
        for (k = 0; k < PAT_BYTES; k++) begin
            b = 8'($urandom_range(255));
            if (b == NEWLINE) b = 8'h0B;
            pat[8*k +: 8] = b;
        end
        set_reg(CFG_PAT_LOW, pat[63:0]);
        set_reg(CFG_PAT_HIGH, pat[127:64]);
        set_reg(CFG_PAT_LEN, 64'd31);
        for (k = 0; k < PAT_BYTES; k++) push(pat[8*k +: 8], 1'b0);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            set_mode(ph % 4);
            set_reg(CFG_PAT_LOW, {$urandom, $urandom});
            set_reg(CFG_PAT_HIGH, {$urandom, $urandom});
            set_reg(CFG_PAT_LEN, {$urandom, 27'($urandom), 5'(lens[ph])});
            if (ph == 5) set_reg(CFG_SPARE, {$urandom, $urandom});
            hold_phase = (ph == 0);
            glen = (eff_len() == 0) ? PATTERN_MAX : eff_len();
            sent = 0;
            while (sent < 210) begin
                r = $urandom_range(99);
                if (r < 45) begin
                    for (k = 0; k < glen; k++)
                        push(pat_text[8*k +: 8], k == 0 && $urandom_range(24) == 0);
                    sent += glen;
                end else if (r < 55) begin
                    n = $urandom_range(glen - 1, 0);
                    for (k = 0; k < n; k++) push(pat_text[8*k +: 8], 1'b0);
                    sent += n;
                end else if (r < 75) begin
                    k = $urandom_range(glen - 1, 0);
                    push(pat_text[8*k +: 8], 1'b0);
                    sent++;
                end else if (r < 87) begin
                    push(NEWLINE, 1'b0);
                    sent++;
                end else begin
                    push(8'($urandom_range(255)), r >= 96);
                    sent++;
                end
            end
            drain();
            hold_phase = 1'b0;
        end

        if (mismatches == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
